[rtl/rstc_pkg.sv]
`default_nettype none
package rstc_pkg;

    // table geometry defaults
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int COUNT_BITS_DEF    = 24;

    // stream widths
    localparam int STATUS_W     = 10;
    localparam int ADDR_W       = 32;
    localparam int TOTAL_W      = 32;
    localparam int TOP_CNT_W    = 24;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 128;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILED_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNAUTH_LIMIT = 1'd1;
    localparam logic [CFG_DATA_W-1:0] FAILED_LIMIT_RST = 32'd100;
    localparam logic [CFG_DATA_W-1:0] UNAUTH_LIMIT_RST = 32'd10;

    // status codes
    localparam logic [STATUS_W-1:0] ST_UNAUTHORIZED = 10'd401;
    localparam logic [STATUS_W-1:0] ST_FORBIDDEN    = 10'd403;
    localparam logic [STATUS_W-1:0] ST_CLIENT_LO    = 10'd400;
    localparam logic [STATUS_W-1:0] ST_SERVER_LO    = 10'd500;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              unauth;
        logic              failed;
    } t_req;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

[rtl/request_status_and_top_source_counter_core.sv]
// Request status and top source counter.
// Slave stream s_axis_* takes one request record per item; master stream
// m_axis_* returns one result item per record, in order. Limits are set via
// i_cfg_we / i_cfg_idx / i_cfg_data (index 0 failed, index 1 unauthorized);
// the user must set them only while the block is idle; it is not enforced.
// The front classifies the status code and places the item in a two-entry
// queue; the back walks the address table, one entry per cycle through a
// single registered read port, then updates counts and the leader.
// On each item the back goes from idle through the scan to a hit or a miss
// state, then to the output state, which loads the output register. A scan
// for a new address covers every filled entry; one for a known address stops
// at its entry, so the time per item varies. The back pops the next item
// from the queue only once it is back in idle.
// Reset clears totals, leader, table fill count and limits (100 and 10);
// table contents are not cleared, as only filled entries are compared.
// If the receiver stalls, the result waits in the output register; the back
// finishes its next item and holds it, and the queue keeps taking items until
// it is full, after which s_axis_tready drops.
`default_nettype none
module request_status_and_top_source_counter_core #(
    parameter int TABLE_ENTRIES = rstc_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = rstc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // status_code[9:0], source_address[41:10], zero pad
    input  wire logic [rstc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // failed_total[31:0], unauthorized_total[63:32], top_address[95:64],
    // top_count[119:96], failed_alert[120], unauthorized_alert[121],
    // address_dropped[122], zero pad
    output logic [rstc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [rstc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rstc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [rstc_pkg::CFG_DATA_W-1:0] r_failed_limit;
    logic [rstc_pkg::CFG_DATA_W-1:0] r_unauth_limit;
    logic                            w_q_ready;
    logic                            w_push;
    rstc_pkg::t_req                  w_front_req;
    logic                            w_q_valid;
    rstc_pkg::t_req                  w_q_req;
    logic                            w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed_limit <= rstc_pkg::FAILED_LIMIT_RST;
            r_unauth_limit <= rstc_pkg::UNAUTH_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rstc_pkg::CFG_FAILED_LIMIT: r_failed_limit <= i_cfg_data;
                rstc_pkg::CFG_UNAUTH_LIMIT: r_unauth_limit <= i_cfg_data;
                default: begin
                    r_failed_limit <= r_failed_limit;
                end
            endcase
        end
    end

    rstc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_q_ready  (w_q_ready),
        .o_push     (w_push),
        .o_req      (w_front_req)
    );

    rstc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_front_req),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_req   (w_q_req)
    );

    rstc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (w_q_valid),
        .i_req          (w_q_req),
        .o_req_pop      (w_pop),
        .i_failed_limit (r_failed_limit),
        .i_unauth_limit (r_unauth_limit),
        .o_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .o_m_tdata      (m_axis_tdata)
    );

endmodule
`default_nettype wire

[rtl/rstc_front.sv]
`default_nettype none
module rstc_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [rstc_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  wire logic                               i_q_ready,
    output logic                                    o_push,
    output rstc_pkg::t_req                          o_req
);

    logic [rstc_pkg::STATUS_W-1:0] w_status;
    logic                          w_unauth;
    logic                          w_client;
    logic                          r_busy_seen;

    assign w_status = i_s_tdata[rstc_pkg::STATUS_W-1:0];
    assign w_unauth = (w_status == rstc_pkg::ST_UNAUTHORIZED) ||
                      (w_status == rstc_pkg::ST_FORBIDDEN);
    assign w_client = (w_status >= rstc_pkg::ST_CLIENT_LO) &&
                      (w_status <  rstc_pkg::ST_SERVER_LO);

    // hold off tready until r_busy_seen has registered the release of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_seen <= 1'b0;
        end else begin
            r_busy_seen <= 1'b1;
        end
    end

    assign o_s_tready  = i_q_ready && r_busy_seen;
    assign o_push      = i_s_tvalid && o_s_tready;
    assign o_req.addr  = i_s_tdata[rstc_pkg::STATUS_W +: rstc_pkg::ADDR_W];
    assign o_req.unauth = w_unauth;
    assign o_req.failed = w_client && !w_unauth;

endmodule
`default_nettype wire

[rtl/rstc_queue.sv]
`default_nettype none
module rstc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  rstc_pkg::t_req      i_req,
    output logic                o_ready,
    input  wire logic           i_pop,
    output logic                o_valid,
    output rstc_pkg::t_req      o_req
);

    localparam int PTR_W = (rstc_pkg::QUEUE_DEPTH > 1) ? $clog2(rstc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(rstc_pkg::QUEUE_DEPTH + 1);

    rstc_pkg::t_req   r_slot [rstc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != CNT_W'(rstc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_slot[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(rstc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(rstc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/rstc_back.sv]
`default_nettype none
module rstc_back #(
    parameter int TABLE_ENTRIES = rstc_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = rstc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_req_valid,
    input  rstc_pkg::t_req                           i_req,
    output logic                                     o_req_pop,
    input  wire logic [rstc_pkg::CFG_DATA_W-1:0]     i_failed_limit,
    input  wire logic [rstc_pkg::CFG_DATA_W-1:0]     i_unauth_limit,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [rstc_pkg::OUT_TDATA_W-1:0]         o_m_tdata
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [31:0] TOP_MAX = 32'((64'd1 << rstc_pkg::TOP_CNT_W) - 1);
    localparam int PAD_W = rstc_pkg::OUT_TDATA_W - 3 * rstc_pkg::TOTAL_W
                           - rstc_pkg::TOP_CNT_W - 3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_HIT  = 5'b00100,
        S_MISS = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                          r_state;
    rstc_pkg::t_req                  r_req;
    logic [CNT_W-1:0]                r_idx;
    logic                            r_cmp_vld;
    logic [CNT_W-1:0]                r_used;
    logic [rstc_pkg::TOTAL_W-1:0]    r_failed;
    logic [rstc_pkg::TOTAL_W-1:0]    r_unauth;
    logic [rstc_pkg::ADDR_W-1:0]     r_lead_addr;
    logic [COUNT_BITS-1:0]           r_lead_cnt;
    logic [COUNT_BITS-1:0]           r_new_cnt;
    logic                            r_dropped;
    logic                            r_out_valid;
    logic [rstc_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic [rstc_pkg::ADDR_W-1:0]     mem_addr [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]           mem_cnt  [TABLE_ENTRIES];
    logic [rstc_pkg::ADDR_W-1:0]     r_rd_addr;
    logic [COUNT_BITS-1:0]           r_rd_cnt;

    logic                            w_wr_addr_en;
    logic                            w_wr_cnt_en;
    logic [IDX_W-1:0]                w_wr_idx;
    logic [COUNT_BITS-1:0]           w_wr_cnt;
    logic [IDX_W-1:0]                w_rd_idx;
    logic                            w_room;
    logic                            w_match;
    logic [31:0]                     w_lead32;
    logic [rstc_pkg::TOP_CNT_W-1:0]  w_top_cnt;
    logic                            w_out_free;

    assign w_rd_idx = r_idx[IDX_W-1:0];
    assign w_room   = (r_used < CNT_W'(TABLE_ENTRIES));
    assign w_match  = r_cmp_vld && (r_rd_addr == r_req.addr);

    always_comb begin
        w_wr_addr_en = 1'b0;
        w_wr_cnt_en  = 1'b0;
        w_wr_idx     = r_used[IDX_W-1:0];
        w_wr_cnt     = COUNT_BITS'(1);
        case (r_state)
            S_HIT: begin
                w_wr_cnt_en = 1'b1;
                w_wr_idx    = IDX_W'(r_idx - 1'b1);
                w_wr_cnt    = r_new_cnt;
            end
            S_MISS: begin
                w_wr_addr_en = w_room;
                w_wr_cnt_en  = w_room;
            end
            default: begin
                w_wr_addr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_addr_en) begin
            mem_addr[w_wr_idx] <= r_req.addr;
        end
        if (w_wr_cnt_en) begin
            mem_cnt[w_wr_idx] <= w_wr_cnt;
        end
        r_rd_addr <= mem_addr[w_rd_idx];
        r_rd_cnt  <= mem_cnt[w_rd_idx];
    end

    assign w_lead32  = 32'(r_lead_cnt);
    assign w_top_cnt = (w_lead32 > TOP_MAX) ? rstc_pkg::TOP_CNT_W'(TOP_MAX)
                                            : w_lead32[rstc_pkg::TOP_CNT_W-1:0];
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_req_pop  = (r_state == S_IDLE) && i_req_valid;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_req <= i_req;
        end
        if (r_state == S_SCAN && w_match) begin
            r_new_cnt <= (r_rd_cnt == COUNT_MAX) ? r_rd_cnt : r_rd_cnt + 1'b1;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_data <= {{PAD_W{1'b0}}, r_dropped,
                           (r_unauth > i_unauth_limit),
                           (r_failed > i_failed_limit),
                           w_top_cnt, r_lead_addr, r_unauth, r_failed};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_used      <= '0;
            r_failed    <= '0;
            r_unauth    <= '0;
            r_lead_addr <= '0;
            r_lead_cnt  <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        if (i_req.unauth) begin
                            r_unauth <= rstc_pkg::sat_inc(r_unauth);
                        end
                        if (i_req.failed) begin
                            r_failed <= rstc_pkg::sat_inc(r_failed);
                        end
                        r_idx     <= '0;
                        r_cmp_vld <= 1'b0;
                        r_dropped <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // compare the entry read last cycle, issue the next read
                    if (w_match) begin
                        r_state <= S_HIT;
                    end else if (r_idx < r_used) begin
                        r_idx     <= r_idx + 1'b1;
                        r_cmp_vld <= 1'b1;
                    end else begin
                        r_state <= S_MISS;
                    end
                end
                S_HIT: begin
                    if (r_new_cnt > r_lead_cnt) begin
                        r_lead_cnt  <= r_new_cnt;
                        r_lead_addr <= r_req.addr;
                    end
                    r_state <= S_OUT;
                end
                S_MISS: begin
                    if (w_room) begin
                        r_used <= r_used + 1'b1;
                        if (r_lead_cnt == '0) begin
                            r_lead_cnt  <= COUNT_BITS'(1);
                            r_lead_addr <= r_req.addr;
                        end
                    end else begin
                        r_dropped <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
`default_nettype wire
